FILE: rtl/sra_pkg.sv
// shared types and constants for the safe resource allocator
// action, status and state codes, beat layout, lane control and flag structs
// no dependencies
package sra_pkg;

	localparam int FIELD_W   = 8;   // width of one amount or claim field on the bus
	localparam int WIDE_W    = 16;  // headroom for clamping fields to the count width
	localparam int LANES_IN  = 4;   // amount and claim fields carried per beat
	localparam int PROC_W    = 3;
	localparam int ACTION_W  = 2;
	localparam int STATUS_W  = 3;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 8;
	localparam int AMT_LSB   = 3;
	localparam int CLM_LSB   = 35;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD     = 2'd0,
		ACT_SET_FREE = 2'd1,
		ACT_REQUEST  = 2'd2,
		ACT_RELEASE  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE       = 3'd0,
		STATUS_OVER_CLAIM = 3'd1,
		STATUS_OVER_FREE  = 3'd2,
		STATUS_UNSAFE     = 3'd3,
		STATUS_OVER_HELD  = 3'd4,
		STATUS_BAD_LOAD   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_FIN
	} state_t;

	// broadcast from the controller to every resource lane
	typedef struct packed {
		logic              walk_init;
		logic              walk_step;
		logic              commit;
		action_t           action;
		logic [PROC_W-1:0] process;
		logic [PROC_W-1:0] pick;
	} lane_ctrl_t;

	// per-lane check results for the selected process row
	typedef struct packed {
		logic over_claim;
		logic over_free;
		logic over_held;
		logic bad_load;
	} lane_flags_t;

	// combined view of all lanes
	typedef struct packed {
		logic              over_claim;
		logic              over_free;
		logic              over_held;
		logic              bad_load;
		logic              any_fit;
		logic              all_done;
		logic [PROC_W-1:0] pick;
	} merge_t;

endpackage

FILE: rtl/sra_lane.sv
// one resource lane: claim and held columns, free count and safety-walk work count
// depends on sra_pkg
module sra_lane
	import sra_pkg::*;
#(
	parameter int PROCESSES  = 8,
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lane_ctrl_t            ctrl,
	input  logic [COUNT_BITS-1:0] amount,
	input  logic [COUNT_BITS-1:0] claim,
	output lane_flags_t           flags,
	output logic [PROCESSES-1:0]  fit
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [COUNT_BITS-1:0] claim_q [PROCESSES];
	logic [COUNT_BITS-1:0] held_q  [PROCESSES];
	logic [COUNT_BITS-1:0] free_q;
	logic [COUNT_BITS-1:0] work_q;

	logic [COUNT_BITS-1:0] held_eff [PROCESSES];
	logic [COUNT_BITS-1:0] sel_claim;
	logic [COUNT_BITS-1:0] sel_held;
	logic [COUNT_BITS-1:0] pick_held;
	logic [COUNT_BITS:0]   work_sum;
	logic [COUNT_BITS:0]   free_sum;

	// trial held column: the requesting row carries the requested units
	always_comb begin
		sel_claim = '0;
		sel_held  = '0;
		pick_held = '0;
		for (int p = 0; p < PROCESSES; p++) begin
			held_eff[p] = held_q[p] + ((ctrl.process == PROC_W'(p)) ? amount : '0);
			fit[p]      = (claim_q[p] - held_eff[p]) <= work_q;
			if (ctrl.process == PROC_W'(p)) begin
				sel_claim = claim_q[p];
				sel_held  = held_q[p];
			end
			if (ctrl.pick == PROC_W'(p)) begin
				pick_held = held_eff[p];
			end
		end
	end

	assign flags.bad_load   = amount > claim;
	assign flags.over_claim = amount > (sel_claim - sel_held);
	assign flags.over_free  = amount > free_q;
	assign flags.over_held  = amount > sel_held;

	assign work_sum = {1'b0, work_q} + {1'b0, pick_held};
	assign free_sum = {1'b0, free_q} + {1'b0, amount};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PROCESSES; p++) begin
				claim_q[p] <= '0;
				held_q[p]  <= '0;
			end
			free_q <= '0;
			work_q <= '0;
		end else begin
			if (ctrl.walk_init) begin
				work_q <= free_q - amount;
			end else if (ctrl.walk_step) begin
				work_q <= work_sum[COUNT_BITS] ? COUNT_MAX : work_sum[COUNT_BITS-1:0];
			end
			if (ctrl.commit) begin
				unique case (ctrl.action)
					ACT_LOAD: begin
						for (int p = 0; p < PROCESSES; p++) begin
							if (ctrl.process == PROC_W'(p)) begin
								claim_q[p] <= claim;
								held_q[p]  <= amount;
							end
						end
					end
					ACT_SET_FREE: begin
						free_q <= amount;
					end
					ACT_REQUEST: begin
						for (int p = 0; p < PROCESSES; p++) begin
							if (ctrl.process == PROC_W'(p)) begin
								held_q[p] <= held_q[p] + amount;
							end
						end
						free_q <= free_q - amount;
					end
					ACT_RELEASE: begin
						for (int p = 0; p < PROCESSES; p++) begin
							if (ctrl.process == PROC_W'(p)) begin
								held_q[p] <= held_q[p] - amount;
							end
						end
						free_q <= free_sum[COUNT_BITS] ? COUNT_MAX : free_sum[COUNT_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/sra_merge.sv
// merging stage: ors the lane checks, ands the lane fit vectors and picks the
// next process to finish in the safety walk; holds the finished-process flags
// depends on sra_pkg
module sra_merge
	import sra_pkg::*;
#(
	parameter int PROCESSES = 8,
	parameter int RESOURCES = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lane_ctrl_t                           ctrl,
	input  lane_flags_t                          lane_flags [RESOURCES],
	input  logic [RESOURCES-1:0][PROCESSES-1:0]  lane_fit,
	output merge_t                               merged
);

	logic [PROCESSES-1:0] done_q;
	logic [PROCESSES-1:0] cand;

	always_comb begin
		merged = '0;
		for (int r = 0; r < RESOURCES; r++) begin
			merged.over_claim = merged.over_claim | lane_flags[r].over_claim;
			merged.over_free  = merged.over_free  | lane_flags[r].over_free;
			merged.over_held  = merged.over_held  | lane_flags[r].over_held;
			merged.bad_load   = merged.bad_load   | lane_flags[r].bad_load;
		end
		// a process can finish when every lane covers its need and it is not done yet
		cand = ~done_q;
		for (int r = 0; r < RESOURCES; r++) begin
			cand = cand & lane_fit[r];
		end
		// lowest index wins
		for (int p = PROCESSES - 1; p >= 0; p--) begin
			if (cand[p]) begin
				merged.pick = PROC_W'(p);
			end
		end
		merged.any_fit  = |cand;
		merged.all_done = &done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (ctrl.walk_init) begin
			done_q <= '0;
		end else if (ctrl.walk_step) begin
			for (int p = 0; p < PROCESSES; p++) begin
				if (merged.pick == PROC_W'(p)) begin
					done_q[p] <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/safe_resource_allocator_core.sv
// top level of the safe resource allocator (banker's scheme)
// depends on sra_pkg, sra_lane and sra_merge
//
// Each input beat carries one action: load a process's claim and held rows, set the
// free-units vector, request units for a process, or release them. Every beat gives
// exactly one result beat with a granted flag and a status code. A request is granted
// only when it stays within the process's remaining need, fits in the free units and
// leaves a state in which every process can still run to completion. One lane per
// resource holds that resource's column of the claim and held tables plus its free
// count; a merging stage combines the lane checks. A beat is taken in the idle state,
// checked in the next cycle, and the result is registered in a finish cycle. A request
// that passes its checks runs the safety walk, which finishes one process per cycle
// (lowest index first among those that fit) and ends once no further process fits.
// A result waiting in the output register does not stop the next beat from being
// taken; only the finish cycle waits for the output register to free up.
// Amounts and claims above 2^COUNT_BITS-1 are clamped; free counts saturate on
// release.
module safe_resource_allocator_core
	import sra_pkg::*;
#(
	parameter int PROCESSES  = 8,
	parameter int RESOURCES  = 4,
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// process [2:0], amount_r0..amount_r3 [34:3], claim_r0..claim_r3 [66:35], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action [1:0]
	input  logic [ACTION_W-1:0]   s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// granted [0], status [3:1], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam logic [WIDE_W-1:0] COUNT_MAX_WIDE = WIDE_W'((32'd1 << COUNT_BITS) - 1);
	localparam logic [PROC_W:0]   PROC_LIMIT     = (PROC_W + 1)'(PROCESSES);

	state_t                state_q;
	state_t                state_nxt;
	action_t               action_q;
	logic [PROC_W-1:0]     proc_q;
	logic [COUNT_BITS-1:0] amt_q [RESOURCES];
	logic [COUNT_BITS-1:0] clm_q [RESOURCES];
	logic [COUNT_BITS-1:0] amt_in [RESOURCES];
	logic [COUNT_BITS-1:0] clm_in [RESOURCES];

	status_t               status_q;
	status_t               check_status;
	logic                  check_walk;
	logic                  in_range;
	logic                  slot_free;
	logic                  accept;

	logic                  out_valid_q;
	status_t               out_status_q;

	lane_ctrl_t            ctrl;
	lane_flags_t           lane_flags [RESOURCES];
	logic [RESOURCES-1:0][PROCESSES-1:0] lane_fit;
	merge_t                merged;

	// unpack and clamp the per-lane fields of the incoming beat
	for (genvar r = 0; r < RESOURCES; r++) begin : g_unpack
		logic [WIDE_W-1:0] amt_wide;
		logic [WIDE_W-1:0] clm_wide;
		assign amt_wide  = WIDE_W'(s_tdata[AMT_LSB + FIELD_W*r +: FIELD_W]);
		assign clm_wide  = WIDE_W'(s_tdata[CLM_LSB + FIELD_W*r +: FIELD_W]);
		assign amt_in[r] = (amt_wide > COUNT_MAX_WIDE) ? COUNT_MAX_WIDE[COUNT_BITS-1:0]
		                                               : amt_wide[COUNT_BITS-1:0];
		assign clm_in[r] = (clm_wide > COUNT_MAX_WIDE) ? COUNT_MAX_WIDE[COUNT_BITS-1:0]
		                                               : clm_wide[COUNT_BITS-1:0];
	end

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign in_range  = {1'b0, proc_q} < PROC_LIMIT;

	// item registers, loaded on the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(s_tuser);
			proc_q   <= s_tdata[PROC_W-1:0];
			for (int r = 0; r < RESOURCES; r++) begin
				amt_q[r] <= amt_in[r];
				clm_q[r] <= clm_in[r];
			end
		end
	end

	// resource lanes
	for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
		sra_lane #(
			.PROCESSES  (PROCESSES),
			.COUNT_BITS (COUNT_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.amount (amt_q[r]),
			.claim  (clm_q[r]),
			.flags  (lane_flags[r]),
			.fit    (lane_fit[r])
		);
	end

	sra_merge #(
		.PROCESSES (PROCESSES),
		.RESOURCES (RESOURCES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.lane_flags (lane_flags),
		.lane_fit   (lane_fit),
		.merged     (merged)
	);

	// action checks in priority order; a request that passes goes to the walk
	always_comb begin
		check_status = STATUS_DONE;
		check_walk   = 1'b0;
		unique case (action_q)
			ACT_LOAD: begin
				if (!in_range || merged.bad_load) begin
					check_status = STATUS_BAD_LOAD;
				end
			end
			ACT_SET_FREE: begin
				check_status = STATUS_DONE;
			end
			ACT_REQUEST: begin
				if (!in_range || merged.over_claim) begin
					check_status = STATUS_OVER_CLAIM;
				end else if (merged.over_free) begin
					check_status = STATUS_OVER_FREE;
				end else begin
					check_walk = 1'b1;
				end
			end
			ACT_RELEASE: begin
				if (!in_range || merged.over_held) begin
					check_status = STATUS_OVER_HELD;
				end
			end
			default: begin
				check_status = STATUS_DONE;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				state_nxt = check_walk ? S_WALK : S_FIN;
			end
			S_WALK: begin
				if (!merged.any_fit) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// controller outputs
	always_comb begin
		ctrl.action    = action_q;
		ctrl.process   = proc_q;
		ctrl.pick      = merged.pick;
		ctrl.walk_init = 1'b0;
		ctrl.walk_step = 1'b0;
		ctrl.commit    = 1'b0;
		s_tready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_CHECK: begin
				ctrl.walk_init = check_walk;
			end
			S_WALK: begin
				ctrl.walk_step = merged.any_fit;
			end
			S_FIN: begin
				ctrl.commit = slot_free && (status_q == STATUS_DONE);
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// status of the item in flight: set by the checks, or by the end of the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= STATUS_DONE;
		end else if (state_q == S_CHECK) begin
			status_q <= check_status;
		end else if (state_q == S_WALK && !merged.any_fit) begin
			status_q <= merged.all_done ? STATUS_DONE : STATUS_UNSAFE;
		end
	end

	// output register, parts the result side from the item side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_DONE;
		end else if (state_q == S_FIN && slot_free) begin
			out_valid_q  <= 1'b1;
			out_status_q <= status_q;
		end else if (m_tready) begin
			out_valid_q  <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - STATUS_W - 1)'(0), out_status_q,
	                   out_status_q == STATUS_DONE};

	// a walk that runs out of candidates always moves on to the finish cycle
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && !merged.any_fit) |=> (state_q == S_FIN))
		else $error("safety walk did not end when no process fits");

	// a walk that leaves some process unfinished is reported unsafe
	a_unsafe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && !merged.any_fit && !merged.all_done)
		|=> (status_q == STATUS_UNSAFE))
		else $error("unfinished walk not reported unsafe");

	// tables change only for a granted item
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> (out_valid_q && out_status_q == STATUS_DONE))
		else $error("state committed without a granted result");

	// no new beat is taken while an item is still being worked on
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!s_tready ##1 !s_tready))
		else $error("beat taken while an item is in flight");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for safe_resource_allocator_core
// scoreboard class predicts each grant and status from its own copy of the tables
// depends on sra_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb_top;
	import sra_pkg::*;

	// block size under test, kept equal to the rtl defaults
	localparam int NPROC        = 8;
	localparam int NRES         = 4;
	localparam int CNT_BITS     = 8;
	localparam int CNT_MAX      = (1 << CNT_BITS) - 1;
	localparam int RAND_BEATS   = 1880;
	localparam int QUIET_TAIL   = 150;
	localparam int DRAIN_CYCLES = 2 * (NPROC + 4);
	localparam int DRAIN_LIMIT  = 20000;

	// one count per resource lane, lane 0 in the low byte
	typedef logic [LANES_IN-1:0][FIELD_W-1:0] lanes_t;

	typedef struct packed {
		logic    granted;
		status_t status;
	} grant_result_t;

	// scoreboard: own copy of claim, held and free, plus the queue of pending results
	class banker_scoreboard;
		lanes_t        claim_tab [NPROC];
		lanes_t        held_tab  [NPROC];
		lanes_t        free_cnt;
		grant_result_t expected_grants [$];
		int            errors;
		int            results_checked;
		int            action_seen [4];
		int            status_seen [8];

		function new();
			for (int p = 0; p < NPROC; p++) begin
				claim_tab[p] = '0;
				held_tab[p]  = '0;
			end
			free_cnt = '0;
			errors = 0;
			results_checked = 0;
			for (int i = 0; i < 4; i++) action_seen[i] = 0;
			for (int i = 0; i < 8; i++) status_seen[i] = 0;
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction

		// safety walk: keep finishing any process whose remaining need fits
		function bit walk_finishes_all(lanes_t avail);
			int               work [NRES];
			bit               done [NPROC];
			int               finished;
			bit               progress;
			bit               fits;
			int               need;
			for (int r = 0; r < NRES; r++) work[r] = int'(avail[r]);
			for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
			finished = 0;
			progress = 1'b1;
			while (progress && finished < NPROC) begin
				progress = 1'b0;
				for (int p = 0; p < NPROC; p++) begin
					if (!done[p]) begin
						fits = 1'b1;
						for (int r = 0; r < NRES; r++) begin
							need = int'(claim_tab[p][r]) - int'(held_tab[p][r]);
							if (need > work[r]) fits = 1'b0;
						end
						if (fits) begin
							done[p] = 1'b1;
							for (int r = 0; r < NRES; r++) work[r] += int'(held_tab[p][r]);
							finished++;
							progress = 1'b1;
						end
					end
				end
			end
			return finished == NPROC;
		endfunction

		// apply one accepted input beat and queue the result it must produce
		function void apply_action(action_t act, logic [PROC_W-1:0] proc, lanes_t amt,
				lanes_t clm);
			status_t       st;
			lanes_t        trial_free;
			lanes_t        old_held;
			int            sum;
			grant_result_t res;
			st = STATUS_DONE;
			case (act)
				ACT_LOAD: begin
					if (proc >= NPROC) st = STATUS_BAD_LOAD;
					for (int r = 0; r < NRES; r++)
						if (amt[r] > clm[r]) st = STATUS_BAD_LOAD;
					if (st == STATUS_DONE) begin
						claim_tab[proc] = clm;
						held_tab[proc]  = amt;
					end
				end
				ACT_SET_FREE: begin
					free_cnt = amt;
				end
				ACT_REQUEST: begin
					if (proc >= NPROC) st = STATUS_OVER_CLAIM;
					else begin
						for (int r = 0; r < NRES; r++)
							if (amt[r] > claim_tab[proc][r] - held_tab[proc][r])
								st = STATUS_OVER_CLAIM;
						if (st == STATUS_DONE)
							for (int r = 0; r < NRES; r++)
								if (amt[r] > free_cnt[r]) st = STATUS_OVER_FREE;
						if (st == STATUS_DONE) begin
							old_held = held_tab[proc];
							for (int r = 0; r < NRES; r++) begin
								held_tab[proc][r] = held_tab[proc][r] + amt[r];
								trial_free[r] = free_cnt[r] - amt[r];
							end
							if (walk_finishes_all(trial_free)) begin
								free_cnt = trial_free;
							end else begin
								held_tab[proc] = old_held;
								st = STATUS_UNSAFE;
							end
						end
					end
				end
				default: begin
					if (proc >= NPROC) st = STATUS_OVER_HELD;
					else begin
						for (int r = 0; r < NRES; r++)
							if (amt[r] > held_tab[proc][r]) st = STATUS_OVER_HELD;
						if (st == STATUS_DONE)
							for (int r = 0; r < NRES; r++) begin
								sum = int'(free_cnt[r]) + int'(amt[r]);
								held_tab[proc][r] = held_tab[proc][r] - amt[r];
								free_cnt[r] = (sum > CNT_MAX) ? FIELD_W'(CNT_MAX)
								                              : FIELD_W'(sum);
							end
					end
				end
			endcase
			res.granted = (st == STATUS_DONE);
			res.status  = st;
			expected_grants.push_back(res);
			action_seen[act]++;
			status_seen[st]++;
		endfunction

		task report(string msg);
			$display("[%0t] error: %s", $time, msg);
			errors++;
		endtask

		// compare one result beat with the oldest pending expectation
		task check_result(logic [OUT_DATA_W-1:0] beat);
			grant_result_t exp;
			logic          got_granted;
			logic [2:0]    got_status;
			got_granted = beat[0];
			got_status  = beat[3:1];
			if (expected_grants.size() == 0) begin
				report($sformatf("result beat %h with nothing pending", beat));
				return;
			end
			exp = expected_grants.pop_front();
			if (got_granted !== exp.granted)
				report($sformatf("result %0d granted %b, predicted %b", results_checked,
					got_granted, exp.granted));
			if (got_status !== exp.status)
				report($sformatf("result %0d status %0d, predicted %0d", results_checked,
					got_status, exp.status));
			results_checked++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// process [2:0], amount_r0..amount_r3 [34:3], claim_r0..claim_r3 [66:35], zero pad
	logic [IN_DATA_W-1:0]  s_tdata;
	// action [1:0]
	logic [ACTION_W-1:0]   s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// granted [0], status [3:1], zero pad
	logic [OUT_DATA_W-1:0] m_tdata;

	banker_scoreboard sb;
	int src_idle_pct;
	int sink_idle_pct;
	int sink_stall_left;

	safe_resource_allocator_core #(
		.PROCESSES (NPROC),
		.RESOURCES (NRES),
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// generous fixed limit, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function lanes_t lanes(int l0, int l1, int l2, int l3);
		lanes_t v;
		v[0] = FIELD_W'(l0);
		v[1] = FIELD_W'(l1);
		v[2] = FIELD_W'(l2);
		v[3] = FIELD_W'(l3);
		return v;
	endfunction

	// idle level for the next stretch of beats: none, light or heavy
	function int idle_level();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 15;
			default: return 40;
		endcase
	endfunction

	// present one beat, hold it until the handshake, then tell the scoreboard
	task send_beat(action_t act, logic [PROC_W-1:0] proc, lanes_t amt, lanes_t clm);
		logic [IN_DATA_W-1:0] packed_beat;
		packed_beat = '0;
		packed_beat[PROC_W-1:0] = proc;
		for (int r = 0; r < LANES_IN; r++) begin
			packed_beat[AMT_LSB + FIELD_W*r +: FIELD_W] = amt[r];
			packed_beat[CLM_LSB + FIELD_W*r +: FIELD_W] = clm[r];
		end
		// optional gap ahead of the beat, lands on any phase of the block's work
		if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= packed_beat;
		// values read here are the ones before this edge's updates
		do @(posedge clk); while (!s_tready);
		sb.apply_action(act, proc, amt, clm);
	endtask

	// result side: check every accepted beat, stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (sink_stall_left > 0) begin
				sink_stall_left = sink_stall_left - 1;
			end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				m_tready <= 1'b0;
				sink_stall_left = $urandom_range(0, 5);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		lanes_t            amt;
		lanes_t            clm;
		lanes_t            zero;
		action_t           act;
		logic [PROC_W-1:0] proc;
		int                pick;
		int                mode;
		int                cap;
		int                need;
		int                waited;

		sb = new();
		zero = '0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = ACT_LOAD;
		s_tdata  = '0;
		m_tready = 1'b0;
		sink_stall_left = 0;
		src_idle_pct  = 30;
		sink_idle_pct = 30;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		// zero request straight after reset, every process has zero need
		send_beat(ACT_REQUEST, 3'd0, zero, zero);
		// set free ignores process and claim fields
		send_beat(ACT_SET_FREE, 3'd5, lanes(255, 255, 255, 255), lanes(255, 255, 255, 255));
		// held equal to claim at the top of the range
		send_beat(ACT_LOAD, 3'd0, lanes(255, 255, 255, 255), lanes(255, 255, 255, 255));
		// held above claim in the top lane only
		send_beat(ACT_LOAD, 3'd1, lanes(0, 0, 0, 1), zero);
		send_beat(ACT_LOAD, 3'd1, zero, lanes(10, 10, 10, 10));
		send_beat(ACT_REQUEST, 3'd1, lanes(11, 0, 0, 0), zero);
		// release into a full free vector saturates
		send_beat(ACT_RELEASE, 3'd0, lanes(255, 255, 255, 255), zero);
		// release above held
		send_beat(ACT_RELEASE, 3'd0, lanes(1, 0, 0, 0), zero);
		send_beat(ACT_LOAD, 3'd0, zero, zero);
		send_beat(ACT_SET_FREE, 3'd0, zero, zero);
		// over claim wins over over free
		send_beat(ACT_REQUEST, 3'd1, lanes(11, 0, 0, 0), zero);
		send_beat(ACT_REQUEST, 3'd1, lanes(0, 0, 0, 1), zero);
		send_beat(ACT_SET_FREE, 3'd0, lanes(5, 5, 5, 5), zero);
		send_beat(ACT_LOAD, 3'd2, zero, lanes(8, 8, 8, 8));
		// fits need and free but the walk gets stuck
		send_beat(ACT_REQUEST, 3'd1, lanes(1, 0, 0, 0), zero);
		// zero request in a state that is already unsafe
		send_beat(ACT_REQUEST, 3'd2, zero, zero);
		send_beat(ACT_SET_FREE, 3'd0, lanes(20, 20, 20, 20), zero);
		send_beat(ACT_REQUEST, 3'd1, lanes(5, 5, 5, 5), zero);
		send_beat(ACT_REQUEST, 3'd3, lanes(255, 255, 255, 255), zero);
		send_beat(ACT_LOAD, 3'd7, zero, lanes(255, 255, 255, 255));
		send_beat(ACT_REQUEST, 3'd7, lanes(255, 255, 255, 255), zero);
		send_beat(ACT_RELEASE, 3'd1, lanes(5, 5, 5, 5), zero);
		send_beat(ACT_RELEASE, 3'd7, zero, zero);
		send_beat(ACT_LOAD, 3'd7, zero, zero);

		// random part, mostly requests and releases shaped by the predicted tables
		for (int i = 0; i < RAND_BEATS; i++) begin
			if (i % 100 == 0) begin
				src_idle_pct  = idle_level();
				sink_idle_pct = idle_level();
			end
			// quiet tail with no idling on either side
			if (i >= RAND_BEATS - QUIET_TAIL) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			proc = PROC_W'($urandom_range(0, NPROC - 1));
			pick = $urandom_range(0, 99);
			mode = $urandom_range(0, 99);
			case ($urandom_range(0, 2))
				0:       cap = 15;
				1:       cap = 63;
				default: cap = CNT_MAX;
			endcase
			amt = '0;
			// claim field is noise for anything but load
			clm = $urandom;
			if (pick < 12) begin
				act = ACT_LOAD;
				for (int r = 0; r < NRES; r++) begin
					clm[r] = FIELD_W'($urandom_range(0, cap));
					if (mode < 80) amt[r] = FIELD_W'($urandom_range(0, clm[r]));
					else amt[r] = FIELD_W'($urandom_range(0, CNT_MAX));
				end
			end else if (pick < 20) begin
				act = ACT_SET_FREE;
				for (int r = 0; r < NRES; r++) amt[r] = FIELD_W'($urandom_range(0, cap));
			end else if (pick < 62) begin
				act = ACT_REQUEST;
				for (int r = 0; r < NRES; r++) begin
					need = int'(sb.claim_tab[proc][r]) - int'(sb.held_tab[proc][r]);
					if (mode < 75) amt[r] = FIELD_W'($urandom_range(0, need));
					else if (mode < 90) begin
						need = need + $urandom_range(0, 3);
						amt[r] = FIELD_W'((need > CNT_MAX) ? CNT_MAX : need);
					end else amt[r] = FIELD_W'($urandom_range(0, CNT_MAX));
				end
			end else begin
				act = ACT_RELEASE;
				for (int r = 0; r < NRES; r++) begin
					need = int'(sb.held_tab[proc][r]);
					if (mode < 75) amt[r] = FIELD_W'($urandom_range(0, need));
					else if (mode < 90) begin
						need = need + $urandom_range(0, 3);
						amt[r] = FIELD_W'((need > CNT_MAX) ? CNT_MAX : need);
					end else amt[r] = FIELD_W'($urandom_range(0, CNT_MAX));
				end
			end
			send_beat(act, proc, amt, clm);
		end
		s_tvalid <= 1'b0;

		// drain, then give a late extra beat time to show up
		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d predicted results never arrived", sb.pending()));

		$display("covered %0d loads, %0d free writes, %0d requests, %0d releases",
			sb.action_seen[ACT_LOAD], sb.action_seen[ACT_SET_FREE],
			sb.action_seen[ACT_REQUEST], sb.action_seen[ACT_RELEASE]);
		$display({"outcomes: %0d done, %0d over claim, %0d over free, %0d unsafe, ",
			"%0d over held, %0d bad load"},
			sb.status_seen[STATUS_DONE], sb.status_seen[STATUS_OVER_CLAIM],
			sb.status_seen[STATUS_OVER_FREE], sb.status_seen[STATUS_UNSAFE],
			sb.status_seen[STATUS_OVER_HELD], sb.status_seen[STATUS_BAD_LOAD]);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/sra_pkg.sv
rtl/sra_lane.sv
rtl/sra_merge.sv
rtl/safe_resource_allocator_core.sv
tb/tb_top.sv
